[rtl/bipb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the box image pyramid builder.
// No dependencies; used by every module of the block.
package bipb_pkg;

  localparam int LevelW     = 3;
  localparam int LevelCap   = 8;
  localparam int ChanW      = 8;
  localparam int SumW       = 10;
  localparam int CfgIndexW  = 4;
  localparam int CfgDataW   = 13;
  localparam int NumLevelsW = 4;
  localparam int RowWidthReset  = 4096;
  localparam int NumLevelsReset = 8;

  typedef enum logic [CfgIndexW-1:0] {
    CfgRowWidth  = 4'd0,
    CfgNumLevels = 4'd1
  } cfg_index_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
  } sum_t;

  // One line store access that needs the combine stage.
  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] level;
    logic              odd_col;
    logic              going;
    pixel_t            pix;
  } issue_t;

  // Pixel handed down to the next level.
  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] level;
    pixel_t            pix;
  } casc_t;

endpackage

[rtl/bipb_line_store.sv]
`timescale 1ns / 1ps
// Single-port line store of saved even-row pixels, all levels packed.
// Depends on bipb_pkg for the pixel type.
module bipb_line_store #(
  parameter int Depth = 8192,
  parameter int AddrW = 13
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    addr_i,
  input  bipb_pkg::pixel_t    wdata_i,
  output bipb_pkg::pixel_t    rdata_o
);

  bipb_pkg::pixel_t mem [Depth];
  bipb_pkg::pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bipb_combine.sv]
`timescale 1ns / 1ps
// Combine stage: adds the saved row to the current pixel, keeps the even
// column pair sums per level and forms the pixel of the next level.
// Depends on bipb_pkg.
module bipb_combine #(
  parameter int LvIdxW = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bipb_pkg::issue_t   issue_i,
  input  bipb_pkg::pixel_t   rdata_i,
  input  logic               take_i,
  output bipb_pkg::casc_t    casc_o
);

  localparam int Slots = 2 ** LvIdxW;

  bipb_pkg::sum_t  pend_q [Slots];
  bipb_pkg::sum_t  sum2;
  bipb_pkg::sum_t  sum4;
  bipb_pkg::sum_t  pend_rd;
  bipb_pkg::casc_t casc_q, casc_d;
  logic [bipb_pkg::LevelW-1:0] nxt_lv;
  logic [LvIdxW-1:0]           pidx;

  assign nxt_lv  = issue_i.level + 1'b1;
  assign pidx    = nxt_lv[LvIdxW-1:0];
  assign pend_rd = pend_q[pidx];

  always_comb begin
    sum2.red   = bipb_pkg::SumW'(rdata_i.red)   + bipb_pkg::SumW'(issue_i.pix.red);
    sum2.green = bipb_pkg::SumW'(rdata_i.green) + bipb_pkg::SumW'(issue_i.pix.green);
    sum2.blue  = bipb_pkg::SumW'(rdata_i.blue)  + bipb_pkg::SumW'(issue_i.pix.blue);
    sum4.red   = pend_rd.red   + sum2.red;
    sum4.green = pend_rd.green + sum2.green;
    sum4.blue  = pend_rd.blue  + sum2.blue;
  end

  always_comb begin
    casc_d = casc_q;
    if (take_i) begin
      casc_d.valid = 1'b0;
    end
    if (issue_i.valid && issue_i.going) begin
      casc_d.valid = 1'b1;
      casc_d.level = nxt_lv;
      if (issue_i.odd_col) begin
        casc_d.pix.red   = sum4.red[bipb_pkg::SumW-1:2];
        casc_d.pix.green = sum4.green[bipb_pkg::SumW-1:2];
        casc_d.pix.blue  = sum4.blue[bipb_pkg::SumW-1:2];
      end else begin
        casc_d.pix.red   = sum2.red[bipb_pkg::ChanW:1];
        casc_d.pix.green = sum2.green[bipb_pkg::ChanW:1];
        casc_d.pix.blue  = sum2.blue[bipb_pkg::ChanW:1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      casc_q <= '0;
      for (int i = 0; i < Slots; i++) begin
        pend_q[i] <= '0;
      end
    end else begin
      casc_q <= casc_d;
      if (issue_i.valid && !issue_i.odd_col) begin
        pend_q[pidx] <= sum2;
      end
    end
  end

  assign casc_o = casc_q;

endmodule

[rtl/box_image_pyramid_builder.sv]
`timescale 1ns / 1ps
// Box image pyramid builder: 2x2 truncating mean per level, one RGB pixel in.
// Depends on bipb_pkg, bipb_line_store and bipb_combine.
//
// Usage: pixels of a row-major image enter on the in channel. Each accepted
// pixel yields one result at level 0 and one more result for every lower
// level it completes; last_in_run_o marks the final result of the pixel.
// Set row_width (index 0) and num_levels (index 1) on the cfg channel while
// the block is idle; cfg_ready_o is always high.
// The level 0 result is valid in the cycle after acceptance. Each further
// level passes the line store read register, then the averaging stage.
// Throughput: one pixel per cycle while no lower level is reached and the
// output is not stalled; a pixel that reaches lower levels holds the issue
// slot until its cascade is done. The single-port line store and the issue
// slot shared by input and cascade set these limits. Reset: counters, row
// parities and pair sums clear; row_width resets to 4096 (clamped to
// MAX_WIDTH), num_levels to 8 (clamped to MAX_LEVELS). The line store is not
// cleared. A stalled receiver holds the output register; the input waits.
module box_image_pyramid_builder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_LEVELS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bipb_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [bipb_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bipb_pkg::ChanW-1:0]         red_in_i,
  input  logic [bipb_pkg::ChanW-1:0]         green_in_i,
  input  logic [bipb_pkg::ChanW-1:0]         blue_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bipb_pkg::LevelW-1:0]        level_o,
  output logic [bipb_pkg::ChanW-1:0]         red_out_o,
  output logic [bipb_pkg::ChanW-1:0]         green_out_o,
  output logic [bipb_pkg::ChanW-1:0]         blue_out_o,
  output logic                               row_end_o,
  output logic                               last_in_run_o
);

  localparam int LvCap  = (MAX_LEVELS < bipb_pkg::LevelCap) ? MAX_LEVELS
                                                            : bipb_pkg::LevelCap;
  localparam int LvIdxW = (LvCap > 1) ? $clog2(LvCap) : 1;
  localparam int Slots  = 2 ** LvIdxW;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int EW     = CW + 1 + (2 ** bipb_pkg::LevelW);

  function automatic int ls_base(input int lv);
    int acc;
    acc = 0;
    for (int j = 0; j < lv; j++) begin
      acc = acc + ((MAX_WIDTH + (1 << j) - 1) >> j);
    end
    return acc;
  endfunction

  localparam int LsRaw   = ls_base(LvCap - 1);
  localparam int LsDepth = (LsRaw < 2) ? 2 : LsRaw;
  localparam int AW      = $clog2(LsDepth);
  localparam int WReset  = (bipb_pkg::RowWidthReset > MAX_WIDTH) ? MAX_WIDTH
                                                               : bipb_pkg::RowWidthReset;
  localparam int NlReset = (bipb_pkg::NumLevelsReset > LvCap) ? LvCap
                                                            : bipb_pkg::NumLevelsReset;

  logic [CW:0]                        w_q;
  logic [bipb_pkg::NumLevelsW-1:0]    nl_q;
  logic [CW-1:0]                      col_q [Slots];
  logic                               par_q [Slots];
  logic [AW-1:0]                      base_w [Slots];

  bipb_pkg::issue_t  issue_q, issue_d;
  bipb_pkg::casc_t   casc;
  bipb_pkg::pixel_t  cur_pix, rdata, out_pix_q;
  logic [bipb_pkg::LevelW-1:0] cur_lv, out_lv_q;
  logic [LvIdxW-1:0] lv_idx;
  logic [CW-1:0]     col;
  logic              par, has_next, row_end, going, out_free, fire, busy;
  logic [EW-1:0]     span;
  logic [AW-1:0]     mem_addr;
  logic              out_valid_q, row_end_q, last_q;
  logic [bipb_pkg::NumLevelsW:0] lv_next;

  for (genvar g = 0; g < Slots; g++) begin : g_base
    assign base_w[g] = (g < LvCap - 1) ? AW'(ls_base(g)) : '0;
  end

  // config writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= (CW + 1)'(WReset);
      nl_q <= bipb_pkg::NumLevelsW'(NlReset);
    end else if (cfg_valid_i) begin
      case (bipb_pkg::cfg_index_e'(cfg_index_i))
        bipb_pkg::CfgRowWidth: begin
          if (cfg_data_i == '0) begin
            w_q <= (CW + 1)'(1);
          end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
            w_q <= (CW + 1)'(MAX_WIDTH);
          end else begin
            w_q <= (CW + 1)'(cfg_data_i);
          end
        end
        bipb_pkg::CfgNumLevels: begin
          if (cfg_data_i[bipb_pkg::NumLevelsW-1:0] == '0) begin
            nl_q <= bipb_pkg::NumLevelsW'(1);
          end else if (32'(cfg_data_i[bipb_pkg::NumLevelsW-1:0]) > 32'(LvCap)) begin
            nl_q <= bipb_pkg::NumLevelsW'(LvCap);
          end else begin
            nl_q <= cfg_data_i[bipb_pkg::NumLevelsW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // issue slot: cascade first, then a new request
  assign busy       = (issue_q.valid && issue_q.going) || casc.valid;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !busy && out_free;
  assign fire       = out_free && (casc.valid || in_valid_i) && !(issue_q.valid && issue_q.going);

  assign cur_lv  = casc.valid ? casc.level : '0;
  assign cur_pix = casc.valid ? casc.pix
                              : bipb_pkg::pixel_t'{red: red_in_i, green: green_in_i,
                                                   blue: blue_in_i};
  assign lv_idx  = cur_lv[LvIdxW-1:0];
  assign col     = col_q[lv_idx];
  assign par     = par_q[lv_idx];
  assign lv_next = (bipb_pkg::NumLevelsW + 1)'(cur_lv) + 1'b1;
  assign has_next = lv_next < (bipb_pkg::NumLevelsW + 1)'(nl_q);
  assign span    = (EW'(col) + 1'b1) << cur_lv;
  assign row_end = span >= EW'(w_q);
  assign going   = has_next && par && (col[0] || row_end);
  assign mem_addr = base_w[lv_idx] + AW'(col);

  always_comb begin
    issue_d         = issue_q;
    issue_d.valid   = fire && has_next && par;
    issue_d.level   = cur_lv;
    issue_d.odd_col = col[0];
    issue_d.going   = going && fire;
    issue_d.pix     = cur_pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Slots; i++) begin
        col_q[i] <= '0;
        par_q[i] <= 1'b0;
      end
    end else begin
      issue_q <= issue_d;
      if (fire) begin
        out_valid_q <= 1'b1;
        if (row_end) begin
          col_q[lv_idx] <= '0;
          par_q[lv_idx] <= !par;
        end else begin
          col_q[lv_idx] <= col + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_lv_q  <= cur_lv;
      out_pix_q <= cur_pix;
      row_end_q <= row_end;
      last_q    <= !going;
    end
  end

  bipb_line_store #(
    .Depth (LsDepth),
    .AddrW (AW)
  ) u_line_store (
    .clk_i   (clk_i),
    .en_i    (fire && has_next),
    .we_i    (!par),
    .addr_i  (mem_addr),
    .wdata_i (cur_pix),
    .rdata_o (rdata)
  );

  bipb_combine #(
    .LvIdxW (LvIdxW)
  ) u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue_q),
    .rdata_i (rdata),
    .take_i  (fire && casc.valid),
    .casc_o  (casc)
  );

  assign out_valid_o   = out_valid_q;
  assign level_o       = out_lv_q;
  assign red_out_o     = out_pix_q.red;
  assign green_out_o   = out_pix_q.green;
  assign blue_out_o    = out_pix_q.blue;
  assign row_end_o     = row_end_q;
  assign last_in_run_o = last_q;

endmodule

[test/box_image_pyramid_builder_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of box_image_pyramid_builder: random image streams
// under changing row widths and level counts, checked by a per-level predictor.
// Depends on bipb_pkg and the box_image_pyramid_builder RTL.
module box_image_pyramid_builder_test;

  localparam int MaxWidth    = 4096;
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 20;
  localparam int RandomItems = 75;
  localparam int CalmItems   = 20;
  localparam int FirstSpareIndex = int'(bipb_pkg::CfgNumLevels) + 1;
  localparam int LastSpareIndex  = (1 << bipb_pkg::CfgIndexW) - 1;

  typedef struct packed {
    logic [bipb_pkg::LevelW-1:0] level;
    bipb_pkg::pixel_t            pix;
    logic                        row_end;
    logic                        run_end;
  } out_pixel_t;

  class pyramid_scoreboard;
    int               row_width;
    int               num_levels;
    int               column[bipb_pkg::LevelCap];
    bit               odd_row[bipb_pkg::LevelCap];
    bipb_pkg::pixel_t saved_row[bipb_pkg::LevelCap][MaxWidth];
    bit               saved_ok[bipb_pkg::LevelCap][MaxWidth];
    bipb_pkg::sum_t   pair_sum[bipb_pkg::LevelCap];
    out_pixel_t       expected_pixels[$];
    int               errors;
    int               results;
    int               per_level[bipb_pkg::LevelCap];

    function new();
      row_width  = bipb_pkg::RowWidthReset;
      num_levels = bipb_pkg::NumLevelsReset;
      for (int i = 0; i < bipb_pkg::LevelCap; i++) begin
        column[i]    = 0;
        odd_row[i]   = 1'b0;
        pair_sum[i]  = '0;
        per_level[i] = 0;
      end
      errors  = 0;
      results = 0;
    endfunction

    function int width_eff(int w);
      if (w < 1) w = 1;
      if (w > MaxWidth) w = MaxWidth;
      return w;
    endfunction

    function int levels_eff(int n);
      if (n < 1) n = 1;
      if (n > bipb_pkg::LevelCap) n = bipb_pkg::LevelCap;
      return n;
    endfunction

    function void write_reg(logic [bipb_pkg::CfgIndexW-1:0] idx,
                            logic [bipb_pkg::CfgDataW-1:0] data);
      if (idx == bipb_pkg::CfgRowWidth) row_width = int'(data);
      else if (idx == bipb_pkg::CfgNumLevels)
        num_levels = int'(data[bipb_pkg::NumLevelsW-1:0]);
    endfunction

    // An odd row must only read line store entries that an even row wrote.
    function bit reads_safe(int w_raw, int n_raw);
      int w, n, c, hi;
      bit ok;
      w  = width_eff(w_raw);
      n  = levels_eff(n_raw);
      ok = 1'b1;
      for (int lv = 0; lv < n - 1; lv++) begin
        if (odd_row[lv]) begin
          c  = (column[lv] >= MaxWidth) ? MaxWidth - 1 : column[lv];
          hi = (w - 1 > c) ? w - 1 : c;
          for (int k = c; k <= hi; k++)
            if (!saved_ok[lv][k]) ok = 1'b0;
        end
        w = (w + 1) >> 1;
      end
      return ok;
    endfunction

    function void predict_pixel(bipb_pkg::pixel_t px);
      int w, n, lv, c;
      bit fin, going, more;
      bipb_pkg::pixel_t cur, held;
      logic [bipb_pkg::SumW-1:0] sr, sg, sb, tr, tg, tb;
      bipb_pkg::sum_t ps;
      out_pixel_t res;
      w    = width_eff(row_width);
      n    = levels_eff(num_levels);
      cur  = px;
      lv   = 0;
      more = 1'b1;
      while (more) begin
        c     = (column[lv] >= MaxWidth) ? MaxWidth - 1 : column[lv];
        fin   = (c + 1 >= w);
        going = 1'b0;
        res.level   = bipb_pkg::LevelW'(lv);
        res.pix     = cur;
        res.row_end = fin;
        res.run_end = 1'b0;
        expected_pixels.insert(expected_pixels.size(), res);
        if (lv + 1 < n) begin
          if (!odd_row[lv]) begin
            saved_row[lv][c] = cur;
            saved_ok[lv][c]  = 1'b1;
          end else begin
            held = saved_row[lv][c];
            sr = {2'b00, held.red} + {2'b00, cur.red};
            sg = {2'b00, held.green} + {2'b00, cur.green};
            sb = {2'b00, held.blue} + {2'b00, cur.blue};
            if (c % 2 == 0) begin
              pair_sum[lv + 1] = {sr, sg, sb};
              if (fin) begin
                cur   = {sr[8:1], sg[8:1], sb[8:1]};
                going = 1'b1;
              end
            end else begin
              ps = pair_sum[lv + 1];
              tr = ps.red + sr;
              tg = ps.green + sg;
              tb = ps.blue + sb;
              cur   = {tr[9:2], tg[9:2], tb[9:2]};
              going = 1'b1;
            end
          end
        end
        if (fin) begin
          column[lv]  = 0;
          odd_row[lv] = ~odd_row[lv];
        end else begin
          column[lv] = c + 1;
        end
        w  = (w + 1) >> 1;
        lv = lv + 1;
        more = going && (lv < n);
      end
      expected_pixels[expected_pixels.size() - 1].run_end = 1'b1;
    endfunction

    function void check_result(out_pixel_t got);
      out_pixel_t want;
      bit bad;
      results++;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel: level %0d rgb %0d/%0d/%0d row_end %0b run_end %0b",
                   got.level, got.pix.red, got.pix.green, got.pix.blue,
                   got.row_end, got.run_end);
        return;
      end
      want = expected_pixels.pop_front();
      bad  = 1'b0;
      if (got.level !== want.level) bad = 1'b1;
      if (got.pix.red !== want.pix.red) bad = 1'b1;
      if (got.pix.green !== want.pix.green) bad = 1'b1;
      if (got.pix.blue !== want.pix.blue) bad = 1'b1;
      if (got.row_end !== want.row_end) bad = 1'b1;
      if (got.run_end !== want.run_end) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want L%0d %0d/%0d/%0d re%0b le%0b, got L%0d %0d/%0d/%0d re%0b le%0b",
                   want.level, want.pix.red, want.pix.green, want.pix.blue,
                   want.row_end, want.run_end,
                   got.level, got.pix.red, got.pix.green, got.pix.blue,
                   got.row_end, got.run_end);
      end else begin
        per_level[got.level]++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [bipb_pkg::CfgIndexW-1:0] cfg_index_i;
  logic [bipb_pkg::CfgDataW-1:0]  cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [bipb_pkg::ChanW-1:0]     red_in_i;
  logic [bipb_pkg::ChanW-1:0]     green_in_i;
  logic [bipb_pkg::ChanW-1:0]     blue_in_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [bipb_pkg::LevelW-1:0]    level_o;
  logic [bipb_pkg::ChanW-1:0]     red_out_o;
  logic [bipb_pkg::ChanW-1:0]     green_out_o;
  logic [bipb_pkg::ChanW-1:0]     blue_out_o;
  logic                           row_end_o;
  logic                           last_in_run_o;

  pyramid_scoreboard sb;
  int pixels_sent;
  int settings_used;
  int cycle_count;
  bit calm;
  bit quiet;

  box_image_pyramid_builder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .level_o       (level_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .row_end_o     (row_end_o),
    .last_in_run_o (last_in_run_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("box_image_pyramid_builder_test: errors");
      $finish;
    end
  end

  // Sample away from the active edge; the request completes at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({level_o, red_out_o, green_out_o, blue_out_o, row_end_o,
                       last_in_run_o});
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic put_reg(input logic [bipb_pkg::CfgIndexW-1:0] idx,
                         input logic [bipb_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input int w, input int nl, input bit spare);
    if (!sb.reads_safe(w, nl)) begin
      w  = sb.row_width;
      nl = sb.num_levels;
    end
    if (spare)
      put_reg(bipb_pkg::CfgIndexW'($urandom_range(FirstSpareIndex, LastSpareIndex)),
              bipb_pkg::CfgDataW'($urandom));
    put_reg(bipb_pkg::CfgRowWidth, bipb_pkg::CfgDataW'(w));
    put_reg(bipb_pkg::CfgNumLevels, bipb_pkg::CfgDataW'(nl));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(input bipb_pkg::pixel_t px);
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= px.red;
    green_in_i <= px.green;
    blue_in_i  <= px.blue;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sb.predict_pixel(px);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [bipb_pkg::ChanW-1:0] random_channel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return bipb_pkg::ChanW'($urandom);
    endcase
  endfunction

  function automatic bipb_pkg::pixel_t corner_pixel(int k);
    case (k % 6)
      0: return {8'd0, 8'd0, 8'd0};
      1: return {8'd255, 8'd255, 8'd255};
      2: return {8'd255, 8'd0, 8'd255};
      3: return {8'd0, 8'd255, 8'd1};
      4: return {8'd128, 8'd127, 8'd170};
      default: return {8'd1, 8'd254, 8'd85};
    endcase
  endfunction

  task automatic run_phase(input int w, input int nl, input int count, input bit corners,
                           input bit spare);
    bipb_pkg::pixel_t px;
    wait_idle();
    quiet = ($urandom_range(0, 3) == 0);
    program_regs(w, nl, spare);
    for (int k = 0; k < count; k++) begin
      calm = (pixels_sent >= 25 + RandomItems - CalmItems);
      if (corners) px = corner_pixel(k);
      else px = {random_channel(), random_channel(), random_channel()};
      send_pixel(px);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int w, nl, burst;
    sb            = new();
    pixels_sent   = 0;
    settings_used = 0;
    cycle_count   = 0;
    calm          = 1'b0;
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    red_in_i      = '0;
    green_in_i    = '0;
    blue_in_i     = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturating values, then width shrunk mid-row to an odd width, then widths 0 and 1
    run_phase(8191, 15, 3, 1'b1, 1'b1);
    run_phase(MaxWidth, bipb_pkg::LevelCap, 2, 1'b1, 1'b0);
    run_phase(3, bipb_pkg::LevelCap, 12, 1'b1, 1'b1);
    run_phase(0, 0, 2, 1'b1, 1'b0);
    run_phase(1, bipb_pkg::LevelCap, 6, 1'b1, 1'b0);

    while (pixels_sent < 25 + RandomItems) begin
      case ($urandom_range(0, 19))
        0: w = 0;
        1: w = MaxWidth;
        2: w = $urandom_range(MaxWidth + 1, (1 << bipb_pkg::CfgDataW) - 1);
        3, 4, 5, 6: w = $urandom_range(7, 40);
        default: w = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0: nl = 0;
        1: nl = $urandom_range(bipb_pkg::LevelCap + 1, (1 << bipb_pkg::NumLevelsW) - 1);
        2, 3: nl = $urandom_range(1, 3);
        4, 5, 6: nl = bipb_pkg::LevelCap;
        default: nl = $urandom_range(4, bipb_pkg::LevelCap);
      endcase
      burst = $urandom_range(6, 24);
      if (burst > 25 + RandomItems - pixels_sent) burst = 25 + RandomItems - pixels_sent;
      run_phase(w, nl, burst, 1'b0, $urandom_range(0, 2) == 0);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d pixels streamed under %0d register settings, %0d results checked",
             pixels_sent, settings_used, sb.results);
    $display("matched results per level 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.per_level[0], sb.per_level[1], sb.per_level[2], sb.per_level[3],
             sb.per_level[4], sb.per_level[5], sb.per_level[6], sb.per_level[7]);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("box_image_pyramid_builder_test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_pixels.size());
      $display("box_image_pyramid_builder_test: errors");
    end
    $finish;
  end

endmodule
